// ===== hdl/lisr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisr_pkg
// Shared constants, types and command/status bundles for the linear
// interpolation stereo resampler.
// ----------------------------------------------------------------------------
package lisr_pkg;

    localparam int PHASE_FRAC_BITS = 20;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 4;
    localparam int STEP_W          = PHASE_FRAC_BITS + 3;
    localparam int SAMPLE_W        = 16;
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int PROD_W          = DIFF_W + PHASE_FRAC_BITS + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = STEP_W;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_TWO  = PHASE_W'(1) << (PHASE_FRAC_BITS + 1);
    localparam logic [STEP_W-1:0]  STEP_MIN   = STEP_W'(1) << (PHASE_FRAC_BITS - 4);
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << PHASE_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic first_only;
        logic in_range;
        logic more;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/lisr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisr_ctrl
// Sequencer: accepts a frame, then alternates range check / multiply and
// output load until the phase passes the limit for this frame.
// ----------------------------------------------------------------------------
module lisr_ctrl
    import lisr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_stat.first_only) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.in_range ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.more ? S_CHECK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.mul    = i_stat.in_range;
                o_cmd.finish = !i_stat.in_range;
            end
            S_EMIT: begin
                o_cmd.emit   = i_stat.out_free;
                o_cmd.finish = i_stat.out_free && !i_stat.more;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/lisr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisr_dp
// Datapath: config registers, frame history, phase accumulator, two
// interpolation multipliers and the output register.
// ----------------------------------------------------------------------------
module lisr_dp
    import lisr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [SAMPLE_W-1:0]  i_left_sample,
    input  logic signed [SAMPLE_W-1:0]  i_right_sample,
    input  logic                        i_last_frame,
    input  logic                        i_out_ready,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    output logic signed [SAMPLE_W-1:0]  o_out_left,
    output logic signed [SAMPLE_W-1:0]  o_out_right,
    output logic                        o_out_last
);

    logic                       r_stereo;
    logic [STEP_W-1:0]          r_step_cfg;
    logic                       r_have_prev;
    logic [PHASE_W-1:0]         r_phase;
    logic signed [SAMPLE_W-1:0] r_prev_l;
    logic signed [SAMPLE_W-1:0] r_prev_r;
    logic                       r_out_valid;

    logic signed [SAMPLE_W-1:0] r_cur_l;
    logic signed [SAMPLE_W-1:0] r_cur_r;
    logic                       r_last;
    logic                       r_limit_two;
    logic signed [SAMPLE_W-1:0] r_base_l;
    logic signed [SAMPLE_W-1:0] r_base_r;
    logic signed [PROD_W-1:0]   r_prod_l;
    logic signed [PROD_W-1:0]   r_prod_r;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;
    logic                       r_out_last;

    logic [STEP_W-1:0]          w_step;
    logic [PHASE_W-1:0]         w_limit;
    logic [PHASE_W:0]           w_phase_sum;
    logic [PHASE_W-1:0]         w_phase_base;
    logic                       w_past_one;
    logic signed [SAMPLE_W-1:0] w_in_r;
    logic signed [SAMPLE_W-1:0] w_a_l;
    logic signed [SAMPLE_W-1:0] w_a_r;
    logic signed [DIFF_W-1:0]   w_diff_l;
    logic signed [DIFF_W-1:0]   w_diff_r;
    logic signed [PHASE_FRAC_BITS:0] w_frac;
    logic signed [PROD_W-1:0]   w_prod_l;
    logic signed [PROD_W-1:0]   w_prod_r;
    logic signed [PROD_W-1:0]   w_sh_l;
    logic signed [PROD_W-1:0]   w_sh_r;
    logic signed [SAMPLE_W-1:0] w_res_l;
    logic signed [SAMPLE_W-1:0] w_res_r;

    always_comb begin
        w_step       = (r_step_cfg < STEP_MIN) ? STEP_MIN : r_step_cfg;
        w_limit      = r_limit_two ? PHASE_TWO : PHASE_ONE;
        w_phase_sum  = {1'b0, r_phase} + (PHASE_W + 1)'(w_step);
        w_phase_base = i_cmd.emit ? w_phase_sum[PHASE_W-1:0] : r_phase;
        w_past_one   = r_phase >= PHASE_ONE;
        w_in_r       = r_stereo ? i_right_sample : i_left_sample;

        // beyond the final frame both neighbors are the final sample
        w_a_l    = w_past_one ? r_cur_l : r_prev_l;
        w_a_r    = w_past_one ? r_cur_r : r_prev_r;
        w_diff_l = DIFF_W'(r_cur_l) - DIFF_W'(w_a_l);
        w_diff_r = DIFF_W'(r_cur_r) - DIFF_W'(w_a_r);
        w_frac   = $signed({1'b0, r_phase[PHASE_FRAC_BITS-1:0]});
        w_prod_l = w_diff_l * w_frac;
        w_prod_r = w_diff_r * w_frac;

        // arithmetic shift is floor division, matching both sign branches
        w_sh_l  = r_prod_l >>> PHASE_FRAC_BITS;
        w_sh_r  = r_prod_r >>> PHASE_FRAC_BITS;
        w_res_l = r_base_l + w_sh_l[SAMPLE_W-1:0];
        w_res_r = r_base_r + w_sh_r[SAMPLE_W-1:0];

        o_stat.first_only = !r_have_prev && !i_last_frame;
        o_stat.in_range   = r_phase < w_limit;
        o_stat.more       = w_phase_sum < {1'b0, w_limit};
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo    <= 1'b1;
            r_step_cfg  <= STEP_RESET;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_STEREO_MODE: r_stereo   <= i_cfg_data[0];
                    REG_STEP_RATIO:  r_step_cfg <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.accept && !r_have_prev) begin
                r_prev_l    <= i_left_sample;
                r_prev_r    <= w_in_r;
                r_phase     <= '0;
                r_have_prev <= !i_last_frame;
            end

            if (i_cmd.finish) begin
                if (r_last) begin
                    r_prev_l    <= '0;
                    r_prev_r    <= '0;
                    r_phase     <= '0;
                    r_have_prev <= 1'b0;
                end else begin
                    r_prev_l <= r_cur_l;
                    r_prev_r <= r_cur_r;
                    r_phase  <= w_phase_base - PHASE_ONE;
                end
            end else if (i_cmd.emit) begin
                r_phase <= w_phase_sum[PHASE_W-1:0];
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_l     <= i_left_sample;
            r_cur_r     <= w_in_r;
            r_last      <= i_last_frame;
            r_limit_two <= i_last_frame && r_have_prev;
        end
        if (i_cmd.mul) begin
            r_base_l <= w_a_l;
            r_base_r <= w_a_r;
            r_prod_l <= w_prod_l;
            r_prod_r <= w_prod_r;
        end
        if (i_cmd.emit) begin
            r_out_l    <= w_res_l;
            r_out_r    <= w_res_r;
            r_out_last <= r_last && !o_stat.more;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_out_last  = r_out_last;

endmodule

// ===== hdl/linear_interp_stereo_resampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_stereo_resampler_top
// Streaming linear-interpolation sample rate converter for 16-bit PCM frames.
//
// Input channel (i_in_valid/o_in_ready) takes one frame per request; output
// channel (o_out_valid/i_out_ready) delivers interpolated frames, o_out_last
// flagging the final result of a frame marked i_last_frame. The config
// channel (i_cfg_valid/o_cfg_ready, always ready) writes stereo_mode (index 0)
// and step_ratio (index 1, Q3.20); the user must write them only while the
// block is idle, and the block itself does not enforce this.
// Sequence: a frame is accepted in the idle state; each result then takes a
// phase check / multiply step and an output load step. A frame that produces
// no results returns to idle from its check step, and the first frame of a
// stream, unless it is also the last, is only stored as history. The datapath
// has two 17x21 multipliers and a single phase accumulator.
// The output register holds a result while the receiver stalls; the
// sequencer waits in its load step until that register frees, and the next
// frame can be accepted while the last result of a frame is still waiting.
// Reset (synchronous, active low) restores stereo mode, a 1.0 step and an
// empty history; no result is pending afterwards.
// ----------------------------------------------------------------------------
module linear_interp_stereo_resampler_top
    import lisr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMPLE_W-1:0]  i_left_sample,
    input  logic signed [SAMPLE_W-1:0]  i_right_sample,
    input  logic                        i_last_frame,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]  o_out_left,
    output logic signed [SAMPLE_W-1:0]  o_out_right,
    output logic                        o_out_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    lisr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lisr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_last_frame   (i_last_frame),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_out_last     (o_out_last)
    );

    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("result loaded over a pending output");

    // no new frame while results of the current one are being produced
    a_accept_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !(w_cmd.emit || w_cmd.mul || w_cmd.finish))
        else $error("frame accepted while busy");

    // finishing a frame always returns to accepting input
    a_finish_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_in_ready)
        else $error("not ready after frame finished");

endmodule

// ===== dv/tb_linear_interp_stereo_resampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_stereo_resampler_top
// Self-checking bench for the linear interpolation resampler. Frames are
// streamed over the valid/ready input with random gaps and output stalls.
// A scoreboard predicts every interpolated frame and its last flag from the
// accepted input and the register settings. It compares each output frame
// in order against that prediction.
// ----------------------------------------------------------------------------
module tb_linear_interp_stereo_resampler_top;
    import lisr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PHASE_ITEMS = 55;
    localparam int          NUM_PHASES = 8;
    // indexes the block has no register for; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } t_stereo_frame;

    class resampler_scoreboard;
        logic                       stereo_en;
        logic [STEP_W-1:0]          step_cfg;
        logic signed [SAMPLE_W-1:0] hist_left;
        logic signed [SAMPLE_W-1:0] hist_right;
        logic                       hist_valid;
        logic [PHASE_W-1:0]         out_pos;
        t_stereo_frame              expected_frames[$];
        int                         mismatches;
        int                         checked;

        function void apply_reset();
            stereo_en   = 1'b1;
            step_cfg    = STEP_RESET;
            hist_left   = '0;
            hist_right  = '0;
            hist_valid  = 1'b0;
            out_pos     = '0;
            expected_frames.delete();
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEREO_MODE: stereo_en = data[0];
                REG_STEP_RATIO:  step_cfg  = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // a + floor((b - a) * frac / 2^FRAC); the result always lies between a and b
        function logic signed [SAMPLE_W-1:0] interp_sample(logic signed [SAMPLE_W-1:0] a,
                logic signed [SAMPLE_W-1:0] b, logic [PHASE_FRAC_BITS-1:0] frac);
            logic signed [DIFF_W-1:0] diff;
            logic signed [PROD_W-1:0] prod;
            diff = b - a;
            prod = diff * $signed({1'b0, frac});
            return a + SAMPLE_W'(prod >>> PHASE_FRAC_BITS);
        endfunction

        function void push_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
            t_stereo_frame f;
            f.left  = l;
            f.right = r;
            f.last  = 1'b0;
            expected_frames.push_back(f);
        endfunction

        function void note_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                logic last);
            logic signed [SAMPLE_W-1:0] cur_left;
            logic signed [SAMPLE_W-1:0] cur_right;
            logic [STEP_W-1:0]          inc;
            int                         base;
            base      = expected_frames.size();
            cur_left  = l;
            cur_right = stereo_en ? r : l;
            inc       = (step_cfg < STEP_MIN) ? STEP_MIN : step_cfg;
            if (hist_valid) begin
                while (out_pos < PHASE_ONE) begin
                    push_frame(interp_sample(hist_left, cur_left, out_pos[PHASE_FRAC_BITS-1:0]),
                               interp_sample(hist_right, cur_right,
                                             out_pos[PHASE_FRAC_BITS-1:0]));
                    out_pos += PHASE_W'(inc);
                end
                out_pos -= PHASE_ONE;
            end else begin
                out_pos    = '0;
                hist_valid = 1'b1;
            end
            hist_left  = cur_left;
            hist_right = cur_right;
            if (last) begin
                // tail: remaining positions clamp to the final frame
                while (out_pos < PHASE_ONE) begin
                    push_frame(cur_left, cur_right);
                    out_pos += PHASE_W'(inc);
                end
                if (expected_frames.size() > base)
                    expected_frames[expected_frames.size() - 1].last = 1'b1;
                hist_left  = '0;
                hist_right = '0;
                hist_valid = 1'b0;
                out_pos    = '0;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] output %0d: %s", $realtime, checked, what);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] l,
                logic signed [SAMPLE_W-1:0] r, logic last);
            t_stereo_frame e;
            if (expected_frames.size() == 0) begin
                flag($sformatf("unexpected frame l=%0d r=%0d last=%0b", l, r, last));
            end else begin
                e = expected_frames.pop_front();
                if (l !== e.left || r !== e.right || last !== e.last)
                    flag($sformatf("expected l=%0d r=%0d last=%0b, got l=%0d r=%0d last=%0b",
                                   e.left, e.right, e.last, l, r, last));
            end
            checked++;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic                       i_last_frame = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_out_left;
    logic signed [SAMPLE_W-1:0] o_out_right;
    logic                       o_out_last;

    resampler_scoreboard sb = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    linear_interp_stereo_resampler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_last_frame   (i_last_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_out_last     (o_out_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_left, o_out_right, o_out_last);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("linear_interp_stereo_resampler_top: mismatch");
            $finish;
        end
    end

    // Leaves valid high after acceptance so back-to-back requests need only one update.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
            input logic signed [SAMPLE_W-1:0] r, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        i_last_frame   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_frame(l, r, last);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic play_stream(input int len);
        for (int k = 0; k < len; k++)
            send_frame(pick_sample(), pick_sample(), k == len - 1);
    endtask

    logic              phase_stereo[NUM_PHASES] =
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [STEP_W-1:0] phase_step[NUM_PHASES] =
        '{23'd1048576, 23'd65536, 23'd4194304, 23'd0, 23'd963379, 23'd1572864,
          23'd786432, 23'd1048576};

    initial begin
        int items;
        int len;
        sb.apply_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stereo, unit step passes frames through
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh0000, 16'shFFFF, 1'b0);
        send_frame(16'shFFFF, 16'sh0000, 1'b0);
        send_frame(16'sh3039, 16'shCFC7, 1'b1);
        // a stream of one frame that is both first and last
        send_frame(16'sh5555, 16'shAAAA, 1'b1);
        wait_idle();

        // mono, zero step raised to the minimum: 32 frames from one pair
        write_reg(REG_STEREO_MODE, '0);
        write_reg(REG_STEP_RATIO, '0);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        send_frame(16'sh8000, 16'sh04D2, 1'b0);
        send_frame(16'sh7FFF, 16'shFFFF, 1'b1);
        wait_idle();

        // largest step: the last frame falls past every output position
        write_reg(REG_STEREO_MODE, CFG_DATA_W'(1));
        write_reg(REG_STEP_RATIO, CFG_DATA_W'(4194304));
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh0064, 16'shFF9C, 1'b0);
        send_frame(16'shFFFF, 16'shFFFF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            write_reg(REG_STEREO_MODE, CFG_DATA_W'(phase_stereo[ph]));
            if (ph == NUM_PHASES - 1)
                write_reg(REG_STEP_RATIO, CFG_DATA_W'($urandom_range(65536, 4194304)));
            else
                write_reg(REG_STEP_RATIO, CFG_DATA_W'(phase_step[ph]));
            items = 0;
            while (items < PHASE_ITEMS) begin
                len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 10);
                play_stream(len);
                items += len;
                // hold off now and then until the output side has drained
                if ($urandom_range(9) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("linear_interp_stereo_resampler_top: match");
        else
            $display("linear_interp_stereo_resampler_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lisr_pkg.sv
hdl/lisr_ctrl.sv
hdl/lisr_dp.sv
hdl/linear_interp_stereo_resampler_top.sv
dv/tb_linear_interp_stereo_resampler_top.sv
